[hw/rtl/ffa_pkg.sv]
// shared types and constants of the first-fit extent page allocator
`default_nettype none
package ffa_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int PAGE_W  = 52;
    localparam int START_W = PAGE_W + 1;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_SKIP = 2'd3;

    localparam logic [4:0] MT_BS_CODE = 5'd3;
    localparam logic [4:0] MT_BS_DATA = 5'd4;
    localparam logic [4:0] MT_CONV    = 5'd7;

    localparam logic [1:0] PL_TAIL  = 2'd0;
    localparam logic [1:0] PL_FRONT = 2'd1;
    localparam logic [1:0] PL_SLOT  = 2'd2;
    localparam logic [1:0] PL_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [4:0]        mem_type;
        logic [PAGE_W-1:0] start_page;
        logic [PAGE_W-1:0] num_pages;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] alloc_page;
    } out_t;

    typedef struct packed {
        logic               valid;
        logic               in_use;
        logic [START_W-1:0] start;
        logic [PAGE_W-1:0]  length;
    } entry_t;

endpackage
`default_nettype wire

[hw/rtl/ffa_table.sv]
// extent table memory, one write port and one registered read port
`default_nettype none
module ffa_table (
    input  wire logic                    aclk,
    input  wire logic [ffa_pkg::IDX_W-1:0] rd_addr,
    output ffa_pkg::entry_t              rd_data,
    input  wire logic                    wr_en,
    input  wire logic [ffa_pkg::IDX_W-1:0] wr_addr,
    input  ffa_pkg::entry_t              wr_data
);
    import ffa_pkg::*;

    entry_t mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[hw/rtl/first_fit_extent_page_allocator.sv]
// top level: sequencer that scans the extent table through one read port
// add takes one table pass; allocate and free take up to two passes
// a scan stops early at the first matching entry; one transaction at a time
// after reset a clearing pass over the whole table marks every entry empty,
// during which no transaction is accepted
`default_nettype none
module first_fit_extent_page_allocator (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  ffa_pkg::in_t  s_data,
    output logic        m_valid,
    input  wire logic   m_ready,
    output ffa_pkg::out_t m_data
);
    import ffa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN_A = 3'd2;
    localparam logic [2:0] S_SCAN_B = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_WR_P   = 3'd5;
    localparam logic [2:0] S_WR_K   = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic [1:0]         op_reg, op_next;
    logic [PAGE_W-1:0]  st_reg, st_next;
    logic [PAGE_W-1:0]  req_reg, req_next;
    logic [START_W-1:0] pst_reg, pst_next;
    logic [PAGE_W-1:0]  plen_reg, plen_next;
    logic [IDX_W-1:0]   k_idx_reg, k_idx_next;
    logic [START_W-1:0] k_start_reg, k_start_next;
    logic [PAGE_W-1:0]  k_len_reg, k_len_next;
    logic [1:0]         kind_reg, kind_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [START_W-1:0] hit_start_reg, hit_start_next;
    logic [PAGE_W-1:0]  hit_len_reg, hit_len_next;
    logic               slot_vld_reg, slot_vld_next;
    logic [IDX_W-1:0]   slot_idx_reg, slot_idx_next;
    logic [1:0]         stat_reg, stat_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    entry_t             rd_data;
    entry_t             wr_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    logic               issue;
    logic               last;
    logic [START_W:0]   e_end;
    logic [START_W:0]   p_end;
    logic               e_free;
    logic               e_tail;
    logic               e_front;
    logic               e_fit;
    logic               e_used;
    logic [PAGE_W-1:0]  rest;
    logic [PAGE_W:0]    merge_sum;
    logic [PAGE_W-1:0]  merge_len;
    logic               usable;
    logic               st_zero;
    logic               merged;

    ffa_table u_table (
        .aclk    (aclk),
        .rd_addr (iss_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign issue   = iss_reg < ENTRIES_C;
    assign last    = ev_vld_reg && (ev_idx_reg == LAST_IDX);
    assign e_end   = {1'b0, rd_data.start} + {2'b0, rd_data.length};
    assign p_end   = {1'b0, pst_reg} + {2'b0, plen_reg};
    assign e_free  = ev_vld_reg && rd_data.valid && !rd_data.in_use;
    assign e_tail  = e_free && (e_end == {1'b0, pst_reg});
    assign e_front = e_free && (p_end == {1'b0, rd_data.start});
    assign e_fit   = e_free && (rd_data.length >= req_reg);
    assign e_used  = ev_vld_reg && rd_data.valid && rd_data.in_use
                     && (rd_data.start == {1'b0, st_reg});
    assign rest    = rd_data.length - req_reg;

    assign merge_sum = {1'b0, hit_len_reg} + {1'b0, plen_reg};
    assign merge_len = merge_sum[PAGE_W] ? {PAGE_W{1'b1}} : merge_sum[PAGE_W-1:0];
    assign merged    = (kind_reg == PL_TAIL) || (kind_reg == PL_FRONT);

    assign usable  = (s_data.mem_type == MT_BS_CODE) || (s_data.mem_type == MT_BS_DATA)
                     || (s_data.mem_type == MT_CONV);
    assign st_zero = s_data.start_page == '0;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = '0;
        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = iss_reg[IDX_W-1:0];
            end
            S_WR_P: begin
                wr_en          = 1'b1;
                wr_data.valid  = 1'b1;
                wr_data.in_use = 1'b0;
                case (kind_reg)
                    PL_TAIL: begin
                        wr_data.start  = hit_start_reg;
                        wr_data.length = merge_len;
                    end
                    PL_FRONT: begin
                        wr_data.start  = pst_reg;
                        wr_data.length = merge_len;
                    end
                    default: begin
                        wr_data.start  = pst_reg;
                        wr_data.length = plen_reg;
                    end
                endcase
            end
            S_WR_K: begin
                wr_en          = 1'b1;
                wr_addr        = k_idx_reg;
                wr_data.start  = k_start_reg;
                if (op_reg == REQ_ALLOC) begin
                    wr_data.valid  = 1'b1;
                    wr_data.in_use = 1'b1;
                    wr_data.length = req_reg;
                end else begin
                    wr_data.valid  = !merged;
                    wr_data.in_use = 1'b0;
                    wr_data.length = k_len_reg;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        ev_vld_next    = 1'b0;
        ev_idx_next    = iss_reg[IDX_W-1:0];
        op_next        = op_reg;
        st_next        = st_reg;
        req_next       = req_reg;
        pst_next       = pst_reg;
        plen_next      = plen_reg;
        k_idx_next     = k_idx_reg;
        k_start_next   = k_start_reg;
        k_len_next     = k_len_reg;
        kind_next      = kind_reg;
        hit_idx_next   = hit_idx_reg;
        hit_start_next = hit_start_reg;
        hit_len_next   = hit_len_reg;
        slot_vld_next  = slot_vld_reg;
        slot_idx_next  = slot_idx_reg;
        stat_next      = stat_reg;
        page_next      = page_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        case (state_reg)
            S_CLEAR: begin
                iss_next = iss_reg + 1'b1;
                if (iss_reg[IDX_W-1:0] == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                iss_next      = '0;
                slot_vld_next = 1'b0;
                page_next     = '0;
                if (s_valid) begin
                    op_next  = s_data.req_type;
                    st_next  = s_data.start_page;
                    req_next = s_data.num_pages;
                    case (s_data.req_type)
                        REQ_ADD: begin
                            pst_next  = st_zero ? START_W'(1) : {1'b0, s_data.start_page};
                            plen_next = st_zero ? s_data.num_pages - 1'b1
                                                : s_data.num_pages;
                            if (!usable || (s_data.num_pages == '0)
                                || (st_zero && (s_data.num_pages == PAGE_W'(1)))) begin
                                stat_next  = ST_SKIP;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_SCAN_B;
                            end
                        end
                        REQ_ALLOC: begin
                            if (s_data.num_pages == '0) begin
                                stat_next  = ST_MISS;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_SCAN_A;
                            end
                        end
                        REQ_FREE: begin
                            state_next = S_SCAN_A;
                        end
                        default: begin
                            stat_next  = ST_MISS;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN_A: begin
                ev_vld_next = issue;
                if (issue) begin
                    iss_next = iss_reg + 1'b1;
                end
                if ((op_reg == REQ_ALLOC) ? e_fit : e_used) begin
                    ev_vld_next  = 1'b0;
                    iss_next     = '0;
                    k_idx_next   = ev_idx_reg;
                    k_start_next = rd_data.start;
                    k_len_next   = rd_data.length;
                    if (op_reg == REQ_ALLOC) begin
                        pst_next  = rd_data.start + START_W'(req_reg);
                        plen_next = rest;
                        if (rest == '0) begin
                            state_next = S_WR_K;
                        end else begin
                            state_next = S_SCAN_B;
                        end
                    end else begin
                        pst_next   = rd_data.start;
                        plen_next  = rd_data.length;
                        state_next = S_SCAN_B;
                    end
                end else if (last) begin
                    stat_next  = ST_MISS;
                    state_next = S_RESP;
                end
            end
            S_SCAN_B: begin
                ev_vld_next = issue;
                if (issue) begin
                    iss_next = iss_reg + 1'b1;
                end
                if (ev_vld_reg && !rd_data.valid && !slot_vld_reg) begin
                    slot_vld_next = 1'b1;
                    slot_idx_next = ev_idx_reg;
                end
                if (e_tail || e_front) begin
                    kind_next      = e_tail ? PL_TAIL : PL_FRONT;
                    hit_idx_next   = ev_idx_reg;
                    hit_start_next = rd_data.start;
                    hit_len_next   = rd_data.length;
                    state_next     = S_DECIDE;
                end else if (last) begin
                    if (slot_vld_reg) begin
                        kind_next    = PL_SLOT;
                        hit_idx_next = slot_idx_reg;
                    end else if (!rd_data.valid) begin
                        kind_next    = PL_SLOT;
                        hit_idx_next = ev_idx_reg;
                    end else begin
                        kind_next = PL_NONE;
                    end
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (op_reg == REQ_FREE) begin
                    state_next = merged ? S_WR_P : S_WR_K;
                end else if (kind_reg == PL_NONE) begin
                    stat_next  = ST_FULL;
                    state_next = S_RESP;
                end else begin
                    state_next = S_WR_P;
                end
            end
            S_WR_P: begin
                if (op_reg == REQ_ADD) begin
                    stat_next  = ST_OK;
                    state_next = S_RESP;
                end else begin
                    state_next = S_WR_K;
                end
            end
            S_WR_K: begin
                stat_next  = ST_OK;
                page_next  = (op_reg == REQ_ALLOC) ? k_start_reg[PAGE_W-1:0] : '0;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = stat_reg;
                    m_data_next.alloc_page = page_reg;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            iss_reg     <= '0;
            ev_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iss_reg     <= iss_next;
            ev_vld_reg  <= ev_vld_next;
            m_valid_reg <= m_valid_next;
        end
        ev_idx_reg    <= ev_idx_next;
        op_reg        <= op_next;
        st_reg        <= st_next;
        req_reg       <= req_next;
        pst_reg       <= pst_next;
        plen_reg      <= plen_next;
        k_idx_reg     <= k_idx_next;
        k_start_reg   <= k_start_next;
        k_len_reg     <= k_len_next;
        kind_reg      <= kind_next;
        hit_idx_reg   <= hit_idx_next;
        hit_start_reg <= hit_start_next;
        hit_len_reg   <= hit_len_next;
        slot_vld_reg  <= slot_vld_next;
        slot_idx_reg  <= slot_idx_next;
        stat_reg      <= stat_next;
        page_reg      <= page_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transaction accepted while busy");

    a_page_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status == ST_OK) || (m_data.alloc_page == '0)))
        else $error("allocated page on failed transaction");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SCAN_A) || (state_reg == S_SCAN_B)) |-> !wr_en)
        else $error("table written during scan");

    a_resp_follows_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR_K) |=> (state_reg == S_RESP))
        else $error("extent update not followed by response");
`endif

endmodule
`default_nettype wire
